### design/imhq_pkg.sv
// Package for the indexed max-heap queue unit.
// Command and status codes, default sizes. No dependencies.
`timescale 1ns / 1ps
package imhq_pkg;
  localparam int NodeCountDefault = 1024;
  localparam int ScoreWidthDefault = 32;
  localparam int NodeW = 10;
  localparam int CountW = 11;
  localparam int InScoreW = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CHANGE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_QUEUED     = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_NOT_QUEUED = 3'd4
  } status_t;
endpackage

### design/indexed_max_heap_queue_unit.sv
// Indexed binary max-heap priority queue with a node position map.
// A request passes lookup, execute and a head read; each sift level walks address, heap read,
// score read, shared compare and swap, with a second pass when both children are tested.
// The next request is taken only after the result has been accepted.
// Clear sweeps the position map; reset runs the same sweep and the block takes no
// request meanwhile. Depends on imhq_pkg.
`timescale 1ns / 1ps
module indexed_max_heap_queue_unit #(
  parameter int NODE_COUNT  = imhq_pkg::NodeCountDefault,
  parameter int SCORE_WIDTH = imhq_pkg::ScoreWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [imhq_pkg::NodeW-1:0]    in_node,
  input  logic signed [imhq_pkg::InScoreW-1:0] in_score,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [imhq_pkg::NodeW-1:0]    out_removed_node,
  output logic [imhq_pkg::NodeW-1:0]    out_head_node,
  output logic signed [imhq_pkg::InScoreW-1:0] out_head_score,
  output logic                          out_was_queued,
  output logic [imhq_pkg::CountW-1:0]   out_entry_count,
  output logic                          out_is_empty
);
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int NW = imhq_pkg::NodeW;
  localparam int SW = SCORE_WIDTH;
  localparam int IW = imhq_pkg::InScoreW;

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_LOOK  = 12'b000000000100,
    S_EXEC  = 12'b000000001000,
    S_RD0   = 12'b000000010000,
    S_RD1   = 12'b000000100000,
    S_RD2   = 12'b000001000000,
    S_CMP   = 12'b000010000000,
    S_SWAP  = 12'b000100000000,
    S_HEAD0 = 12'b001000000000,
    S_HEAD1 = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  // phases of the sift walk
  typedef enum logic [2:0] {
    PH_UP  = 3'b001,
    PH_DN  = 3'b010,
    PH_FIN = 3'b100
  } phase_t;

  logic [AW-1:0] heap_mem [NODE_COUNT];
  logic [SW-1:0] score_mem [NODE_COUNT];
  logic [CW-1:0] pos_mem [NODE_COUNT];

  state_t state_r;
  phase_t ph_r;
  logic [CW-1:0] fill_r;
  logic [AW-1:0] clr_r;
  logic          act_r;          // request in progress
  logic [1:0]    cmd_r;
  logic [NW-1:0] node_r;
  logic [SW-1:0] sc_r;
  logic          inr_r, queued_r;
  logic [2:0]    status_r;
  logic [NW-1:0] removed_r;
  logic [CW-1:0] cur_r;          // slot being sifted
  logic [CW:0]   oth_r;          // parent or child slot under test
  logic          right_r;        // right child pending
  logic [AW-1:0] ncur_r, noth_r, nl_r;
  logic [SW-1:0] kcur_r, koth_r, kl_r;
  logic [AW-1:0] hrd_r;          // registered heap read
  logic [SW-1:0] srd_r;          // registered score read
  logic [CW-1:0] prd_r;          // registered position read
  logic          ov_r;
  logic [NW-1:0] hn_r;
  logic [SW-1:0] hs_r;

  logic [AW-1:0] h_ra, s_ra, p_ra;
  logic          cmp_gt, oth_ge;
  logic [SW-1:0] bias;

  assign bias = {1'b1, {(SW-1){1'b0}}};
  // shared compare: is the other key larger than the current one
  assign cmp_gt = (koth_r ^ bias) > (kcur_r ^ bias);
  assign oth_ge = cmp_gt || (koth_r == kcur_r);

  always_ff @(posedge clk) begin
    hrd_r <= heap_mem[h_ra];
    srd_r <= score_mem[s_ra];
    prd_r <= pos_mem[p_ra];
  end

  // read addresses
  always_comb begin
    h_ra = AW'(cur_r);
    s_ra = hrd_r;
    p_ra = AW'(node_r);
    unique case (state_r)
      S_RD0, S_RD1: h_ra = AW'(oth_r);
      S_HEAD0, S_HEAD1: h_ra = '0;
      default: ;
    endcase
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready = (state_r == S_IDLE) && !ov_r;

  logic [CW:0] lchild;
  assign lchild = {cur_r, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
      act_r   <= 1'b0;
      ph_r    <= PH_FIN;
    end else begin
      if (out_acc) ov_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          pos_mem[clr_r] <= '0;
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(NODE_COUNT - 1)) state_r <= S_HEAD0;
        end
        S_IDLE: if (in_acc) begin
          cmd_r  <= in_cmd;
          node_r <= in_node;
          sc_r   <= SW'(in_score);
          inr_r  <= 32'(in_node) < NODE_COUNT;
          removed_r <= '0;
          status_r  <= imhq_pkg::ST_OK;
          cur_r  <= '0;
          act_r  <= 1'b1;
          state_r <= S_LOOK;
        end
        S_LOOK: state_r <= S_EXEC;  // pos_mem and heap_mem[0] reads land
        S_EXEC: begin
          queued_r <= inr_r && (prd_r != '0);
          state_r <= S_HEAD0;
          unique case (cmd_r)
            imhq_pkg::CMD_CLEAR: begin
              fill_r <= '0; clr_r <= '0; state_r <= S_CLR;
            end
            imhq_pkg::CMD_INSERT:
              if (fill_r >= CW'(NODE_COUNT) || !inr_r) status_r <= imhq_pkg::ST_FULL;
              else if (prd_r != '0) status_r <= imhq_pkg::ST_QUEUED;
              else begin
                score_mem[AW'(node_r)] <= sc_r;
                heap_mem[AW'(fill_r)] <= AW'(node_r);
                pos_mem[AW'(node_r)] <= fill_r + 1'b1;
                cur_r <= fill_r; ncur_r <= AW'(node_r); kcur_r <= sc_r;
                fill_r <= fill_r + 1'b1;
                ph_r <= PH_UP; state_r <= S_RD0;
                oth_r <= {1'b0, (fill_r - 1'b1) >> 1};
              end
            imhq_pkg::CMD_REMOVE:
              if (fill_r == '0) status_r <= imhq_pkg::ST_EMPTY;
              else begin
                removed_r <= NW'(hrd_r);
                pos_mem[hrd_r] <= '0;
                fill_r <= fill_r - 1'b1;
                if (fill_r > CW'(1)) begin
                  // move last entry to top; read it next
                  cur_r <= fill_r - 1'b1;
                  oth_r <= {1'b0, fill_r - 1'b1};
                  ph_r <= PH_FIN; state_r <= S_RD0;
                  noth_r <= hrd_r;
                end
              end
            default:
              if (!(inr_r && prd_r != '0)) status_r <= imhq_pkg::ST_NOT_QUEUED;
              else begin
                score_mem[AW'(node_r)] <= sc_r;
                cur_r <= prd_r - 1'b1; ncur_r <= AW'(node_r); kcur_r <= sc_r;
                oth_r <= {1'b0, (prd_r - 2'd2) >> 1};
                ph_r <= PH_UP; state_r <= S_RD0;
              end
          endcase
        end
        S_RD0: begin
          // removal: fetch last entry, up phase: test if at root, down phase: stop if no child
          if (ph_r == PH_UP && cur_r == '0) begin
            ph_r <= PH_DN; oth_r <= lchild; right_r <= 1'b0;
          end else if (ph_r == PH_DN && oth_r >= {1'b0, fill_r}) begin
            state_r <= S_HEAD0;
          end else state_r <= S_RD1;
        end
        S_RD1: state_r <= S_RD2;     // hrd_r valid
        S_RD2: begin
          noth_r <= (ph_r == PH_FIN) ? noth_r : hrd_r;
          if (ph_r == PH_FIN) ncur_r <= hrd_r;
          state_r <= S_CMP;           // srd_r valid next
        end
        S_CMP: begin
          if (ph_r == PH_FIN) begin
            // place last entry at root
            heap_mem['0] <= ncur_r;
            pos_mem[ncur_r] <= CW'(1);
            kcur_r <= srd_r;
            cur_r <= '0;
            ph_r <= PH_DN; oth_r <= {1'b0, CW'(1)}; right_r <= 1'b0;
            state_r <= S_RD0;
          end else begin
            koth_r <= srd_r;
            state_r <= S_SWAP;
          end
        end
        S_SWAP: begin
          state_r <= S_RD0;
          if (ph_r == PH_UP) begin
            if (oth_ge) ph_r <= PH_DN;
            else begin
              heap_mem[AW'(cur_r)] <= noth_r; pos_mem[noth_r] <= cur_r + 1'b1;
              heap_mem[AW'(oth_r)] <= ncur_r; pos_mem[ncur_r] <= CW'(oth_r) + 1'b1;
              cur_r <= CW'(oth_r);
              oth_r <= {1'b0, (CW'(oth_r) - 1'b1) >> 1};
              if (oth_r != '0) ph_r <= PH_UP;
              else begin ph_r <= PH_DN; oth_r <= {1'b0, CW'(1)}; end
            end
            if (oth_ge) begin oth_r <= lchild; end
            right_r <= 1'b0;
          end else if (!right_r) begin
            // left child read; try right
            nl_r <= noth_r; kl_r <= koth_r;
            right_r <= 1'b1;
            if (oth_r + 1'b1 >= {1'b0, fill_r}) begin
              right_r <= 1'b0;
              if (cmp_gt) begin
                heap_mem[AW'(cur_r)] <= noth_r; pos_mem[noth_r] <= cur_r + 1'b1;
                heap_mem[AW'(oth_r)] <= ncur_r; pos_mem[ncur_r] <= CW'(oth_r) + 1'b1;
                cur_r <= CW'(oth_r); oth_r <= {CW'(oth_r), 1'b1};
              end else state_r <= S_HEAD0;
            end else oth_r <= oth_r + 1'b1;
          end else begin
            right_r <= 1'b0;
            if (cmp_gt && (koth_r ^ bias) >= (kl_r ^ bias)) begin
              heap_mem[AW'(cur_r)] <= noth_r; pos_mem[noth_r] <= cur_r + 1'b1;
              heap_mem[AW'(oth_r)] <= ncur_r; pos_mem[ncur_r] <= CW'(oth_r) + 1'b1;
              cur_r <= CW'(oth_r); oth_r <= {CW'(oth_r), 1'b1};
            end else if ((kl_r ^ bias) > (kcur_r ^ bias)) begin
              heap_mem[AW'(cur_r)] <= nl_r; pos_mem[nl_r] <= cur_r + 1'b1;
              heap_mem[AW'(oth_r - 1'b1)] <= ncur_r;
              pos_mem[ncur_r] <= CW'(oth_r);
              cur_r <= CW'(oth_r - 1'b1); oth_r <= {CW'(oth_r - 1'b1), 1'b1};
            end else state_r <= S_HEAD0;
          end
        end
        S_HEAD0: state_r <= S_HEAD1;
        S_HEAD1: state_r <= S_OUT;   // hrd_r holds the head node
        S_OUT: begin
          hn_r <= NW'(hrd_r);
          hs_r <= srd_r;
          ov_r <= act_r;
          act_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = status_r;
  assign out_removed_node = removed_r;
  assign out_head_node    = (fill_r == '0) ? '0 : hn_r;
  assign out_head_score   = (fill_r == '0) ? '0 : IW'($signed(hs_r));
  assign out_was_queued   = queued_r;
  assign out_entry_count  = imhq_pkg::CountW'(fill_r);
  assign out_is_empty     = (fill_r == '0);

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE && !out_valid))
    else $error("ready outside idle");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(NODE_COUNT))
    else $error("fill count overflow");
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag mismatch");
`endif
endmodule
